// File: rtl/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// Shared constants, types and functions of the weather particle step core.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int HalfX = 1310720;
    localparam int HalfY = 1310720;
    localparam int HalfZ = 1310720;
    localparam int TrigDepth = 1024;
    localparam int TrigBits = $clog2(TrigDepth);

    localparam logic [20:0] RateX  = 21'd1162061;
    localparam logic [19:0] RateZ  = 20'd888635;
    localparam logic [16:0] PhaseZ = 17'd85852;
    localparam logic [31:0] HashMul = 32'd2246822519;
    localparam logic [31:0] MixMulA = 32'h7feb352d;
    localparam logic [31:0] MixMulB = 32'h846ca68b;

    localparam logic [2:0] RegStepX  = 3'd0;
    localparam logic [2:0] RegStepY  = 3'd1;
    localparam logic [2:0] RegStepZ  = 3'd2;
    localparam logic [2:0] RegSway   = 3'd3;
    localparam logic [2:0] RegCentX  = 3'd4;
    localparam logic [2:0] RegCentY  = 3'd5;
    localparam logic [2:0] RegCentZ  = 3'd6;
    localparam logic [2:0] RegClock  = 3'd7;

    typedef struct packed {
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic signed [31:0] step_z;
        logic [30:0]        sway_step;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [31:0]        clock_ms;
    } wps_cfg_t;

    // Quarter-wave sine polynomial, Q15, input 0..16384.
    function automatic logic signed [16:0] quarter_sine(input logic [14:0] x);
        logic [31:0] z;
        logic [31:0] z2;
        logic [31:0] t;
        logic [47:0] r;
        z  = {16'd0, x, 1'b0};
        z2 = (z * z) >> 15;
        t  = 32'd21024 - ((z2 * 32'd2320) >> 15);
        t  = 32'd51472 - ((z2 * t) >> 15);
        r  = ({16'd0, z} * {16'd0, t}) >> 15;
        quarter_sine = (r > 48'd32767) ? 17'sd32767 : $signed({1'b0, r[15:0]});
    endfunction

    function automatic logic signed [16:0] isin(input logic [15:0] a);
        logic [14:0] x;
        logic signed [16:0] v;
        x = {1'b0, a[13:0]};
        v = a[14] ? quarter_sine(15'd16384 - x) : quarter_sine(x);
        isin = a[15] ? -v : v;
    endfunction

    // Table entry k holds the sine at angle k * 65536 / depth.
    function automatic logic signed [16:0] trig_entry(input logic [TrigBits-1:0] k);
        logic [15:0] a;
        a = 16'(k) << (16 - TrigBits);
        trig_entry = isin(a);
    endfunction

endpackage

// File: rtl/wps_sway.sv
// ----------------------------------------------------------------------------
// wps_sway
// Angle generation, sine lookup and sway products, three registered stages.
// ----------------------------------------------------------------------------
module wps_sway
    import wps_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  wps_cfg_t            cfg,
    input  logic [15:0]         sway_phase,
    output logic signed [48:0]  sx,
    output logic signed [48:0]  sz
);
    logic [15:0] ax_reg, az_reg;
    logic signed [16:0] cx_reg, sn_reg;
    logic signed [48:0] sx_reg, sz_reg;
    logic [52:0] px;
    logic [51:0] pz;
    logic [32:0] pp;

    // Sine table over one full turn, read at two addresses per cycle while enabled.
    logic signed [16:0] sin_rom [TrigDepth];

    initial
    begin
        for (int k = 0; k < TrigDepth; k++)
        begin
            sin_rom[k] = trig_entry(TrigBits'(k));
        end
    end

    always_comb
    begin
        px = {21'd0, cfg.clock_ms} * {32'd0, RateX};
        pz = {20'd0, cfg.clock_ms} * {32'd0, RateZ};
        pp = {17'd0, sway_phase} * {16'd0, PhaseZ};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= px[31:16] + sway_phase + 16'd16384;
            az_reg <= pz[31:16] + pp[31:16];
            cx_reg <= sin_rom[ax_reg[15 -: TrigBits]];
            sn_reg <= sin_rom[az_reg[15 -: TrigBits]];
            sx_reg <= (49'($signed({1'b0, cfg.sway_step})) * 49'(cx_reg)) >>> 15;
            sz_reg <= (49'($signed({1'b0, cfg.sway_step})) * 49'(sn_reg)) >>> 15;
        end
    end

    assign sx = sx_reg;
    assign sz = sz_reg;
endmodule

// File: rtl/wps_hash.sv
// ----------------------------------------------------------------------------
// wps_hash
// Respawn hash: seed, two multiply rounds, scatter scaling, four stages.
// ----------------------------------------------------------------------------
module wps_hash
    import wps_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  wps_cfg_t           cfg,
    input  logic [16:0]        particle_index,
    output logic signed [33:0] off_x,
    output logic signed [33:0] off_z
);
    logic [31:0] n_reg, a_reg, b_reg, ha_reg, hb_reg;
    logic signed [33:0] ox_reg, oz_reg;
    logic [31:0] n0, n1, t0, t1;
    logic signed [32:0] ux, uz;
    logic signed [65:0] mx, mz;

    function automatic logic [31:0] shx(input logic [31:0] v, input int s);
        shx = v ^ (v >> s);
    endfunction

    always_comb
    begin
        n0 = shx(n_reg, 16);
        n1 = shx(n_reg + 32'd1, 16);
        t0 = shx(a_reg, 15);
        t1 = shx(b_reg, 15);
        // Twice the hash minus 2^32 fits 33 signed bits: flip the top bit.
        ux = $signed({~ha_reg[31], ha_reg[30:0], 1'b0});
        uz = $signed({~hb_reg[31], hb_reg[30:0], 1'b0});
        mx = 66'(ux) * 66'(HalfX);
        mz = 66'(uz) * 66'(HalfZ);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= 32'(particle_index) * HashMul + cfg.clock_ms;
            a_reg  <= n0 * MixMulA;
            b_reg  <= n1 * MixMulA;
            ha_reg <= shx(t0 * MixMulB, 16);
            hb_reg <= shx(t1 * MixMulB, 16);
            ox_reg <= mx[65:32];
            oz_reg <= mz[65:32];
        end
    end

    assign off_x = ox_reg;
    assign off_z = oz_reg;
endmodule

// File: rtl/weather_particle_step_core.sv
// ----------------------------------------------------------------------------
// weather_particle_step_core
// Advances one weather particle by one frame: drift, sway, respawn and wrap.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload
// in        in_valid/stall   particle_index, pos_x, pos_y, pos_z, sway_phase
// out       out_valid/stall  out_index, new_x, new_y, new_z, respawned
// cfg       APB              registers at 4*i, 32-bit data
//
// One transaction is accepted every cycle unless the output stalls; items pass
// the six-stage delay line that the three-stage sway path and the four-stage hash
// path join, followed by the combine stage that feeds the output registers.
// Reset clears the valid bits and all configuration registers.
// A stall on a valid output freezes every stage together, so nothing is lost.
// ----------------------------------------------------------------------------
module weather_particle_step_core
    import wps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [16:0]        particle_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        sway_phase,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        out_index,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [31:0] new_z,
    output logic               respawned
);
    localparam int Depth = 6;

    wps_cfg_t cfg_reg;
    logic [2:0] reg_sel;
    logic en;

    // Delay line for the item fields; valid bits travel alongside.
    logic [Depth-1:0] vld_reg;
    logic [16:0] idx_reg [Depth];
    logic signed [31:0] px_reg [Depth];
    logic signed [31:0] py_reg [Depth];
    logic signed [31:0] pz_reg [Depth];

    logic signed [48:0] sx, sz;
    logic signed [33:0] off_x, off_z;

    // Final stage: combine and wrap.
    logic signed [50:0] xs, zs, xr, zr, xv, zv, ys;
    logic resp;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;
    logic [16:0] oi_reg;
    logic rs_reg, ov_reg;

    assign reg_sel = paddr[4:2];
    assign pready  = 1'b1;
    assign en = !(ov_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                RegStepX: cfg_reg.step_x    <= pwdata;
                RegStepY: cfg_reg.step_y    <= pwdata;
                RegStepZ: cfg_reg.step_z    <= pwdata;
                RegSway:  cfg_reg.sway_step <= pwdata[30:0];
                RegCentX: cfg_reg.center_x  <= pwdata;
                RegCentY: cfg_reg.center_y  <= pwdata;
                RegCentZ: cfg_reg.center_z  <= pwdata;
                RegClock: cfg_reg.clock_ms  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            RegStepX: prdata = cfg_reg.step_x;
            RegStepY: prdata = cfg_reg.step_y;
            RegStepZ: prdata = cfg_reg.step_z;
            RegSway:  prdata = {1'b0, cfg_reg.sway_step};
            RegCentX: prdata = cfg_reg.center_x;
            RegCentY: prdata = cfg_reg.center_y;
            RegCentZ: prdata = cfg_reg.center_z;
            RegClock: prdata = cfg_reg.clock_ms;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
            ov_reg  <= vld_reg[Depth-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg[0] <= particle_index;
            px_reg[0]  <= pos_x;
            py_reg[0]  <= pos_y;
            pz_reg[0]  <= pos_z;
            for (int i = 1; i < Depth; i++)
            begin
                idx_reg[i] <= idx_reg[i-1];
                px_reg[i]  <= px_reg[i-1];
                py_reg[i]  <= py_reg[i-1];
                pz_reg[i]  <= pz_reg[i-1];
            end
        end
    end

    wps_sway u_sway (
        .clk        (clk),
        .en         (en),
        .cfg        (cfg_reg),
        .sway_phase (sway_phase),
        .sx         (sx),
        .sz         (sz)
    );

    wps_hash u_hash (
        .clk            (clk),
        .en             (en),
        .cfg            (cfg_reg),
        .particle_index (particle_index),
        .off_x          (off_x),
        .off_z          (off_z)
    );

    // Sway arrives after three stages and the hash offsets after four; both
    // are held here so that they line up with the end of the delay line.
    logic signed [48:0] sx_d_reg [3];
    logic signed [48:0] sz_d_reg [3];
    logic signed [33:0] ox_d_reg [2];
    logic signed [33:0] oz_d_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_d_reg[0] <= sx;
            sz_d_reg[0] <= sz;
            sx_d_reg[1] <= sx_d_reg[0];
            sz_d_reg[1] <= sz_d_reg[0];
            sx_d_reg[2] <= sx_d_reg[1];
            sz_d_reg[2] <= sz_d_reg[1];
            ox_d_reg[0] <= off_x;
            oz_d_reg[0] <= off_z;
            ox_d_reg[1] <= ox_d_reg[0];
            oz_d_reg[1] <= oz_d_reg[0];
        end
    end

    function automatic logic signed [50:0] wrap(input logic signed [50:0] v,
                                                 input logic signed [31:0] c,
                                                 input int half);
        logic signed [50:0] cc;
        cc = 51'(c);
        if (v < cc - 51'(half))
            wrap = v + 51'(2 * half);
        else if (v > cc + 51'(half))
            wrap = v - 51'(2 * half);
        else
            wrap = v;
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [50:0] v);
        if (v > 51'sd2147483647)
            sat = 32'sh7fffffff;
        else if (v < -51'sd2147483648)
            sat = 32'sh80000000;
        else
            sat = v[31:0];
    endfunction

    always_comb
    begin
        xs = 51'(px_reg[Depth-1]) + 51'(cfg_reg.step_x) + 51'(sx_d_reg[2]);
        zs = 51'(pz_reg[Depth-1]) + 51'(cfg_reg.step_z) + 51'(sz_d_reg[2]);
        ys = 51'(py_reg[Depth-1]) + 51'(cfg_reg.step_y);
        resp = ys < 51'(cfg_reg.center_y) - 51'(HalfY);
        xr = resp ? 51'(cfg_reg.center_x) + 51'(ox_d_reg[1]) : xs;
        zr = resp ? 51'(cfg_reg.center_z) + 51'(oz_d_reg[1]) : zs;
        if (resp)
            ys = ys + 51'(2 * HalfY);
        else if (ys > 51'(cfg_reg.center_y) + 51'(HalfY))
            ys = ys - 51'(2 * HalfY);
        xv = wrap(xr, cfg_reg.center_x, HalfX);
        zv = wrap(zr, cfg_reg.center_z, HalfZ);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= sat(xv);
            ny_reg <= sat(ys);
            nz_reg <= sat(zv);
            oi_reg <= idx_reg[Depth-1];
            rs_reg <= resp;
        end
    end

    assign out_valid = ov_reg;
    assign out_index = oi_reg;
    assign new_x     = nx_reg;
    assign new_y     = ny_reg;
    assign new_z     = nz_reg;
    assign respawned = rs_reg;

    // A stalled result holds and the pipeline freezes with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_x) && $stable(vld_reg))
        else $error("stalled result moved");
    // Input is stalled exactly while a result is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");
    // An item at the end of the delay line moves into the output register when free.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Depth-1] && !in_stall |=> out_valid)
        else $error("item lost in pipeline");
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams particles through the step core under random input gaps and output
// stalls, and compares every result against an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import wps_pkg::*;

    // The drain wait adds a margin after the last expected result.
    localparam int DrainCycles = 40;
    localparam int CycleLimit  = 400000;
    localparam int RandomItems = 1000;

    typedef struct packed {
        logic [16:0]        index;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        phase;
    } particle_t;

    typedef struct packed {
        logic [16:0]        index;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               resp;
    } update_t;

    // One row of the directed table; check_fixed marks rows whose result is
    // typed in by hand in addition to the prediction.
    typedef struct {
        particle_t p;
        bit        check_fixed;
        update_t   fixed;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [16:0]        particle_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        sway_phase;
    logic               out_valid;
    logic               out_stall;
    logic [16:0]        out_index;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               respawned;

    // Shadow of the configuration registers, used by the predictor.
    logic signed [31:0] sh_step_x, sh_step_y, sh_step_z;
    logic [30:0]        sh_sway;
    logic signed [31:0] sh_cx, sh_cy, sh_cz;
    logic [31:0]        sh_clock;

    update_t            pending_updates[$];
    int                 error_count;
    int                 cycle_count;
    bit                 hold_off_req;
    bit                 stim_done;

    weather_particle_step_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .sway_phase     (sway_phase),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_index      (out_index),
        .new_x          (new_x),
        .new_y          (new_y),
        .new_z          (new_z),
        .respawned      (respawned)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor. Position arithmetic is carried in 64-bit signed values so the
    // sums before wrap and saturation are exact.
    // ------------------------------------------------------------------
    function automatic longint sine_q15(input logic [15:0] a);
        logic [15:0] quarter_pos;
        longint      z, z2, t, r, v;
        // Snap the angle to the table grid first.
        a = (a >> (16 - TrigBits)) << (16 - TrigBits);
        quarter_pos = a[14] ? 16'd16384 - {2'b00, a[13:0]} : {2'b00, a[13:0]};
        z  = longint'(quarter_pos) * 2;
        z2 = (z * z) >>> 15;
        t  = 21024 - ((z2 * 2320) >>> 15);
        t  = 51472 - ((z2 * t) >>> 15);
        r  = (z * t) >>> 15;
        v  = (r > 32767) ? 32767 : r;
        return a[15] ? -v : v;
    endfunction

    function automatic logic [31:0] hash32(input logic [31:0] n);
        n = n ^ (n >> 16);
        n = n * MixMulA;
        n = n ^ (n >> 15);
        n = n * MixMulB;
        n = n ^ (n >> 16);
        return n;
    endfunction

    // Maps a hash to a point uniformly spread over centre +/- half.
    function automatic longint scatter_axis(input longint c, input logic [31:0] h,
                                            input longint half);
        longint u;
        u = longint'({32'd0, h}) * 2 - 64'sd4294967296;
        return c + ((u * half) >>> 32);
    endfunction

    function automatic longint wrap_once(input longint v, input longint c,
                                         input longint half);
        if (v < c - half) return v + 2 * half;
        if (v > c + half) return v - 2 * half;
        return v;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic update_t predict_step(input particle_t p);
        update_t     u;
        logic [15:0] ang_x, ang_z;
        logic [31:0] seed;
        longint      x, y, z, sx, sz, sway;
        ang_x = 16'((64'(sh_clock) * RateX) >> 16) + p.phase;
        ang_z = 16'((64'(sh_clock) * RateZ) >> 16) + 16'((64'(p.phase) * PhaseZ) >> 16);
        sway  = longint'({33'd0, sh_sway});
        sx = (sway * sine_q15(ang_x + 16'd16384)) >>> 15;
        sz = (sway * sine_q15(ang_z)) >>> 15;
        x = longint'(p.px) + longint'(sh_step_x) + sx;
        y = longint'(p.py) + longint'(sh_step_y);
        z = longint'(p.pz) + longint'(sh_step_z) + sz;
        u.resp = 1'b0;
        if (y < longint'(sh_cy) - HalfY) begin
            // Fell out of the bottom: re-enter at the top at a hashed spot.
            seed = 32'(p.index) * HashMul + sh_clock;
            y = y + 2 * longint'(HalfY);
            x = scatter_axis(longint'(sh_cx), hash32(seed), HalfX);
            z = scatter_axis(longint'(sh_cz), hash32(seed + 32'd1), HalfZ);
            u.resp = 1'b1;
        end
        else if (y > longint'(sh_cy) + HalfY) begin
            y = y - 2 * longint'(HalfY);
        end
        x = wrap_once(x, longint'(sh_cx), HalfX);
        z = wrap_once(z, longint'(sh_cz), HalfZ);
        u.index = p.index;
        u.nx = clamp32(x);
        u.ny = clamp32(y);
        u.nz = clamp32(z);
        return u;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes: setup cycle, then access cycle. The shadow copy
    // is updated together with the register.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] reg_id, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_id)
            RegStepX: sh_step_x = value;
            RegStepY: sh_step_y = value;
            RegStepZ: sh_step_z = value;
            RegSway:  sh_sway   = value[30:0];
            RegCentX: sh_cx     = value;
            RegCentY: sh_cy     = value;
            RegCentZ: sh_cz     = value;
            RegClock: sh_clock  = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz, input logic [31:0] sw,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [31:0] ck);
        write_reg(RegStepX, sx);
        write_reg(RegStepY, sy);
        write_reg(RegStepZ, sz);
        write_reg(RegSway, sw);
        write_reg(RegCentX, cx);
        write_reg(RegCentY, cy);
        write_reg(RegCentZ, cz);
        write_reg(RegClock, ck);
    endtask

    // Waits until every expected transaction has come out, then lets the
    // pipeline settle before anything else happens.
    task automatic wait_drained();
        while (pending_updates.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Offers one transaction and holds it until the core takes it. The
    // expectation is queued at the accepting edge.
    task automatic send_particle(input particle_t p);
        in_valid       <= 1'b1;
        particle_index <= p.index;
        pos_x          <= p.px;
        pos_y          <= p.py;
        pos_z          <= p.pz;
        sway_phase     <= p.phase;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_updates.push_back(predict_step(p));
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
    endtask

    function automatic particle_t random_particle(input int mode);
        particle_t p;
        longint    span;
        p.index = 17'($urandom);
        p.phase = 16'($urandom);
        span = 2 * longint'(HalfY);
        case (mode)
            // Near the box, so that wrap and respawn both happen often.
            0: begin
                p.px = 32'(longint'(sh_cx) + $signed($urandom_range(0, 6 * HalfX)) - 3 * HalfX);
                p.py = 32'(longint'(sh_cy) + $signed($urandom_range(0, 3 * span)) - (3 * span) / 2);
                p.pz = 32'(longint'(sh_cz) + $signed($urandom_range(0, 6 * HalfZ)) - 3 * HalfZ);
            end
            // Anywhere in the range, including the saturation corners.
            default: begin
                p.px = $urandom;
                p.py = $urandom;
                p.pz = $urandom;
            end
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: a stall pattern of its own, plus a long hold-off when the
    // stimulus asks for it so the pipeline backs up into in_stall.
    // ------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int run;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                hold_off_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 20);
            repeat (run) begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Output checker: sampled at the rising edge on values driven before it.
    always @(posedge clk) begin
        update_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected transaction: index %0d", out_index);
                error_count++;
            end
            else begin
                want = pending_updates.pop_front();
                if (out_index !== want.index) begin
                    $error("out_index: expected %0d, got %0d", want.index, out_index);
                    error_count++;
                end
                if (new_x !== want.nx) begin
                    $error("new_x: expected %0d, got %0d", want.nx, new_x);
                    error_count++;
                end
                if (new_y !== want.ny) begin
                    $error("new_y: expected %0d, got %0d", want.ny, new_y);
                    error_count++;
                end
                if (new_z !== want.nz) begin
                    $error("new_z: expected %0d, got %0d", want.nz, new_z);
                    error_count++;
                end
                if (respawned !== want.resp) begin
                    $error("respawned: expected %0d, got %0d", want.resp, respawned);
                    error_count++;
                end
            end
        end
    end

    // Hand-typed results are checked alongside the predictor's.
    update_t fixed_updates[$];
    bit      fixed_flags[$];
    always @(posedge clk) begin
        update_t want;
        bit      use_it;
        if (rst_n && out_valid && !out_stall && fixed_flags.size() != 0) begin
            use_it = fixed_flags.pop_front();
            want   = fixed_updates.pop_front();
            if (use_it && {out_index, new_x, new_y, new_z, respawned} !== want) begin
                $error("directed row: expected %h, got %h", want,
                       {out_index, new_x, new_y, new_z, respawned});
                error_count++;
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin : stimulus
        directed_row_t rows[$];
        directed_row_t row;
        particle_t     p;
        update_t       zero_u;
        int            phase_id;
        int            sent;
        int            burst;
        int            gap;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        particle_index = '0;
        pos_x          = '0;
        pos_y          = '0;
        pos_z          = '0;
        sway_phase     = '0;
        error_count    = 0;
        cycle_count    = 0;
        hold_off_req   = 1'b0;
        stim_done      = 1'b0;
        sh_step_x = '0; sh_step_y = '0; sh_step_z = '0; sh_sway = '0;
        sh_cx = '0; sh_cy = '0; sh_cz = '0; sh_clock = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at reset configuration: every step and centre is
        // zero, so a particle inside the box comes back unchanged.
        zero_u = '0;
        row.check_fixed = 1'b1;
        row.p = '{17'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0};
        row.fixed = '{17'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0};
        rows.push_back(row);
        row.p = '{17'h1ffff, 32'sd65536, -32'sd65536, 32'sd1310720, 16'hffff};
        row.fixed = '{17'h1ffff, 32'sd65536, -32'sd65536, 32'sd1310720, 1'b0};
        rows.push_back(row);
        // Above the top edge wraps down by the full box height.
        row.p = '{17'd5, 32'sd0, 32'sd1310721, 32'sd0, 16'd0};
        row.fixed = '{17'd5, 32'sd0, -32'sd1310719, 32'sd0, 1'b0};
        rows.push_back(row);
        // Side wrap on x and z, in opposite directions.
        row.p = '{17'd6, 32'sd1310721, 32'sd0, -32'sd1310721, 16'd0};
        row.fixed = '{17'd6, -32'sd1310719, 32'sd0, 32'sd1310719, 1'b0};
        rows.push_back(row);
        // Range extremes wrap once only, and are not brought back in.
        row.p = '{17'd7, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h8000};
        row.fixed = '{17'd7, 32'sh7fffffff - 32'sd2621440, 32'sh7fffffff - 32'sd2621440,
                      32'sh80000000 + 32'sd2621440, 1'b0};
        rows.push_back(row);
        row.check_fixed = 1'b0;
        row.fixed = zero_u;
        // Below bottom: respawn, hashed spots from predictor; edge row stays.
        row.p = '{17'd0, 32'sd0, -32'sd1310721, 32'sd0, 16'd0};
        rows.push_back(row);
        row.p = '{17'h1ffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'h4000};
        rows.push_back(row);
        row.p = '{17'd12345, 32'sd100, -32'sd1310720, 32'sd100, 16'hc000};
        rows.push_back(row);
        foreach (rows[i]) begin
            fixed_flags.push_back(rows[i].check_fixed);
            fixed_updates.push_back(rows[i].fixed);
            send_particle(rows[i].p);
        end
        go_idle();
        wait_drained();
        fixed_flags.delete();

        // Largest sway and steps that push results into saturation.
        write_all(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff);
        for (int i = 0; i < 12; i++) begin
            p = random_particle(i % 2);
            if (i < 4) p.phase = 16'(i * 16384);
            send_particle(p);
        end
        go_idle();
        wait_drained();

        // Random phases, each under a fresh configuration. Most items stay
        // close to the box so that wrap and respawn are exercised.
        sent = 0;
        phase_id = 0;
        while (sent < RandomItems) begin
            if (phase_id % 2 == 0)
                write_all($signed($urandom_range(0, 262144)) - 131072,
                          $signed($urandom_range(0, 524288)) - 393216,
                          $signed($urandom_range(0, 262144)) - 131072,
                          $urandom_range(0, 131072),
                          $signed($urandom_range(0, 20000000)) - 10000000,
                          $signed($urandom_range(0, 20000000)) - 10000000,
                          $signed($urandom_range(0, 20000000)) - 10000000,
                          $urandom);
            else
                write_all($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            if (phase_id == 1) hold_off_req = 1'b1;
            for (int k = 0; k < 125 && sent < RandomItems; ) begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst; b++) begin
                    send_particle(random_particle($urandom_range(0, 4) == 0));
                    sent++;
                    k++;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    go_idle();
                    repeat (gap) @(posedge clk);
                end
            end
            go_idle();
            // The sender pauses here until everything has come out.
            wait_drained();
            phase_id++;
        end

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
